[hdl/tms_pkg.sv]
// Shared types, constants and the control program of the tone melody sequencer.
package tms_pkg;

  // Field widths of the channels.
  localparam int KIND_W  = 3;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int LEN_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int NOTE_W  = 4;
  localparam int TOP_W   = 16;
  localparam int CLK_W   = 25;

  // The prescaler divides by 8 and the square wave toggles twice a period: 16 in all.
  localparam int PRESCALE_SHIFT = 4;
  localparam int DIVIDEND_W     = CLK_W - PRESCALE_SHIFT;

  localparam logic [CLK_W-1:0] CPU_CLOCK_RESET = CLK_W'(16000000);
  localparam logic [TOP_W-1:0] TOP_MAX         = 16'hFFFF;
  localparam int               MAX_NOTES_DEF   = 16;

  // One note store entry: duration above frequency.
  localparam int ENTRY_W = FREQ_W + DUR_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MELODY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;

  // Program steps. The last step falls through to the first.
  typedef enum logic [3:0] {
    S_FETCH    = 4'd0,
    S_DISPATCH = 4'd1,
    S_TICK     = 4'd2,
    S_TICK_DEC = 4'd3,
    S_TICK_CHK = 4'd4,
    S_TICK_END = 4'd5,
    S_ADVANCE  = 4'd6,
    S_MELODY   = 4'd7,
    S_MEL_SET  = 4'd8,
    S_SINGLE   = 4'd9,
    S_WAIT_RD  = 4'd10,
    S_LD_NOTE  = 4'd11,
    S_TONE     = 4'd12,
    S_DIV_WAIT = 4'd13,
    S_TONE_SET = 4'd14,
    S_EMIT     = 4'd15
  } step_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_DEC,
    DP_ADVANCE,
    DP_MEL_START,
    DP_SINGLE,
    DP_LOAD_NOTE,
    DP_DIV_START,
    DP_TONE_SET,
    DP_SILENT,
    DP_STORE,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_IF,
    BR_DISPATCH
  } br_op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_NO_IN,
    C_NOT_SOUNDING,
    C_REM_NONZERO,
    C_NO_NEXT_NOTE,
    C_LEN_ZERO,
    C_FREQ_ZERO,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    dp_op_t dp;
    br_op_t br;
    cond_t  cond;
    step_t  target;
  } ucw_t;

  function automatic ucw_t make_ucw(dp_op_t dp, br_op_t br, cond_t cond, step_t target);
    ucw_t w;
    w.dp     = dp;
    w.br     = br;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The control program, one word per step. A load item writes the note store while it is
  // dispatched, then goes straight to the result.
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    case (s)
      S_FETCH:    w = make_ucw(DP_LATCH,     BR_IF,       C_NO_IN,        S_FETCH);
      S_DISPATCH: w = make_ucw(DP_STORE,     BR_DISPATCH, C_NONE,         S_EMIT);
      S_TICK:     w = make_ucw(DP_NONE,      BR_IF,       C_NOT_SOUNDING, S_EMIT);
      S_TICK_DEC: w = make_ucw(DP_DEC,       BR_NEXT,     C_NONE,         S_EMIT);
      S_TICK_CHK: w = make_ucw(DP_NONE,      BR_IF,       C_REM_NONZERO,  S_EMIT);
      S_TICK_END: w = make_ucw(DP_NONE,      BR_IF,       C_NO_NEXT_NOTE, S_TONE_SET);
      S_ADVANCE:  w = make_ucw(DP_ADVANCE,   BR_JUMP,     C_NONE,         S_WAIT_RD);
      S_MELODY:   w = make_ucw(DP_NONE,      BR_IF,       C_LEN_ZERO,     S_TONE_SET);
      S_MEL_SET:  w = make_ucw(DP_MEL_START, BR_JUMP,     C_NONE,         S_WAIT_RD);
      S_SINGLE:   w = make_ucw(DP_SINGLE,    BR_JUMP,     C_NONE,         S_TONE);
      S_WAIT_RD:  w = make_ucw(DP_NONE,      BR_NEXT,     C_NONE,         S_EMIT);
      S_LD_NOTE:  w = make_ucw(DP_LOAD_NOTE, BR_NEXT,     C_NONE,         S_EMIT);
      S_TONE:     w = make_ucw(DP_DIV_START, BR_NEXT,     C_NONE,         S_EMIT);
      S_DIV_WAIT: w = make_ucw(DP_NONE,      BR_IF,       C_DIV_BUSY,     S_DIV_WAIT);
      S_TONE_SET: w = make_ucw(DP_TONE_SET,  BR_JUMP,     C_NONE,         S_EMIT);
      S_EMIT:     w = make_ucw(DP_EMIT,      BR_IF,       C_OUT_FULL,     S_EMIT);
      default:    w = make_ucw(DP_NONE,      BR_JUMP,     C_NONE,         S_FETCH);
    endcase
    return w;
  endfunction

  // Entry step for each item kind.
  function automatic step_t dispatch(logic [KIND_W-1:0] k);
    step_t s;
    case (k)
      KIND_TICK:   s = S_TICK;
      KIND_TONE:   s = S_SINGLE;
      KIND_MELODY: s = S_MELODY;
      KIND_LOAD:   s = S_EMIT;
      KIND_STOP:   s = S_TONE_SET;
      default:     s = S_EMIT;
    endcase
    return s;
  endfunction

endpackage

[hdl/tms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tms_div.sv]
// Restoring divider producing one quotient bit per cycle.
module tms_div #(
  parameter int DIVIDEND_W = tms_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = tms_pkg::FREQ_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // The partial remainder stays below the divisor, so the shifted value fits one extra bit.
  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= '0;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
      count    <= count + 1'b1;
      if (count == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hdl/tone_melody_sequencer.sv]
// Top level of the tone melody sequencer: microcoded control, datapath and note store.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_valid / cfg_ready  cfg_data (cpu_clock_hz, 25 bits)
//   in       in         in_valid / in_ready    kind, frequency_hz, length_ms,
//                                              melody_length, note_slot
//   out      out        out_valid / out_ready  tone_active, compare_top,
//                                              melody_running, current_note
//
// Items are handled one at a time. A single tone, a melody start and a tick that moves on to
// the next note each run the 21-step restoring divider in tms_div, one quotient bit per cycle,
// unless the frequency is zero. The next item can be taken once a result is offered, even while
// that result still waits on the output. Reset is synchronous; the note store is not cleared,
// so its entries hold nothing useful until they have been loaded. A stalled output holds the
// program at its final step.
module tone_melody_sequencer #(
  parameter int MAX_NOTES = tms_pkg::MAX_NOTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tms_pkg::CLK_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tms_pkg::KIND_W-1:0]  kind,
  input  logic [tms_pkg::FREQ_W-1:0]  frequency_hz,
  input  logic [tms_pkg::DUR_W-1:0]   length_ms,
  input  logic [tms_pkg::LEN_W-1:0]   melody_length,
  input  logic [tms_pkg::SLOT_W-1:0]  note_slot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        tone_active,
  output logic [tms_pkg::TOP_W-1:0]   compare_top,
  output logic                        melody_running,
  output logic [tms_pkg::NOTE_W-1:0]  current_note
);

  import tms_pkg::*;

  localparam int IDX_W = $clog2(MAX_NOTES);
  localparam int CNT_W = $clog2(MAX_NOTES + 1);

  // Program control.
  step_t step;
  step_t step_next;
  ucw_t  ucw;
  logic  cond_true;

  // Configuration.
  logic [CLK_W-1:0] cpu_clock_hz;

  // The item being worked on.
  logic [KIND_W-1:0] item_kind;
  logic [FREQ_W-1:0] item_freq;
  logic [DUR_W-1:0]  item_dur;
  logic [LEN_W-1:0]  item_len;
  logic [SLOT_W-1:0] item_slot;

  // Operands of the tone being started.
  logic [FREQ_W-1:0] op_freq;
  logic [DUR_W-1:0]  op_dur;

  // Sequencer state.
  logic              sounding;
  logic [DUR_W-1:0]  remaining_ms;
  logic [CNT_W-1:0]  notes_in_melody;
  logic [IDX_W-1:0]  note_position;
  logic [TOP_W-1:0]  divider_top;

  // Divider and note store.
  logic                  div_start;
  logic                  div_busy;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic [DIVIDEND_W-1:0] quot_dec;
  logic [TOP_W-1:0]      top_clamped;
  logic                  store_we;
  logic                  slot_ok;
  logic [ENTRY_W-1:0]    store_rdata;
  logic [CNT_W-1:0]      len_sat;
  logic                  has_next_note;
  logic                  out_full;

  // The tone-set step also serves as the silence step. It is reached on silence from a
  // stop item, an empty melody, a melody that has played out, or a zero frequency; only
  // after the divider step does it start a tone.
  logic silence_path;
  logic came_from_div;

  assign ucw       = ucode(step);
  assign cfg_ready = 1'b1;
  assign in_ready  = (step == S_FETCH);
  assign out_full  = out_valid && !out_ready;

  // A melody plays on while the following position is still inside its length.
  assign has_next_note = (notes_in_melody != '0) &&
                         ((32'(note_position) + 32'd1) < 32'(notes_in_melody));

  assign len_sat = (32'(item_len) > MAX_NOTES) ? CNT_W'(MAX_NOTES) : CNT_W'(item_len);
  assign slot_ok = 32'(item_slot) < MAX_NOTES;

  // Compare top is the quotient less one, held at zero and clamped to 16 bits.
  assign quot_dec    = (div_quotient == '0) ? '0 : div_quotient - 1'b1;
  assign top_clamped = (quot_dec > DIVIDEND_W'(TOP_MAX)) ? TOP_MAX : quot_dec[TOP_W-1:0];

  assign div_start = (ucw.dp == DP_DIV_START);
  // The dispatch step writes the store only for a load item aimed at an existing slot.
  assign store_we  = (ucw.dp == DP_STORE) && (item_kind == KIND_LOAD) && slot_ok;

  always_comb begin
    case (ucw.cond)
      C_NO_IN:        cond_true = !in_valid;
      C_NOT_SOUNDING: cond_true = !sounding;
      C_REM_NONZERO:  cond_true = (remaining_ms != '0);
      C_NO_NEXT_NOTE: cond_true = !has_next_note;
      C_LEN_ZERO:     cond_true = (item_len == '0);
      C_FREQ_ZERO:    cond_true = (op_freq == '0);
      C_DIV_BUSY:     cond_true = div_busy;
      C_OUT_FULL:     cond_true = out_full;
      default:        cond_true = 1'b0;
    endcase
  end

  // Sequencing: fall through, jump, conditional jump or dispatch on the item kind.
  // Steps that jump on a condition fall through to the following step otherwise, and the
  // step after the last is the first. Silence and stop share the tone-set step through
  // the special handling below.
  always_comb begin
    case (ucw.br)
      BR_NEXT:     step_next = step_t'(step + 4'd1);
      BR_JUMP:     step_next = ucw.target;
      BR_IF:       step_next = cond_true ? ucw.target : step_t'(step + 4'd1);
      BR_DISPATCH: step_next = dispatch(item_kind);
      default:     step_next = S_FETCH;
    endcase
    // A tone of zero frequency goes straight to silence without a division.
    if (step == S_TONE && op_freq == '0) begin
      step_next = S_TONE_SET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= S_FETCH;
      cpu_clock_hz    <= CPU_CLOCK_RESET;
      sounding        <= 1'b0;
      remaining_ms    <= '0;
      notes_in_melody <= '0;
      note_position   <= '0;
      divider_top     <= '0;
      out_valid       <= 1'b0;
    end else begin
      step <= step_next;

      if (cfg_valid && cfg_ready) begin
        cpu_clock_hz <= cfg_data;
      end

      // The emit step reloads the output register itself when the old result leaves.
      if (out_valid && out_ready && ucw.dp != DP_EMIT) begin
        out_valid <= 1'b0;
      end

      case (ucw.dp)
        DP_LATCH: begin
          if (in_valid) begin
            item_kind <= kind;
            item_freq <= frequency_hz;
            item_dur  <= length_ms;
            item_len  <= melody_length;
            item_slot <= note_slot;
          end
        end
        DP_DEC: begin
          if (remaining_ms != '0) begin
            remaining_ms <= remaining_ms - 1'b1;
          end
        end
        DP_ADVANCE: begin
          note_position <= note_position + 1'b1;
        end
        DP_MEL_START: begin
          notes_in_melody <= len_sat;
          note_position   <= '0;
        end
        DP_SINGLE: begin
          notes_in_melody <= '0;
          op_freq         <= item_freq;
          op_dur          <= item_dur;
        end
        DP_LOAD_NOTE: begin
          op_freq <= store_rdata[FREQ_W-1:0];
          op_dur  <= store_rdata[ENTRY_W-1:FREQ_W];
        end
        DP_TONE_SET: begin
          // Reached with a fresh quotient after a division, and otherwise to silence.
          if (step_t'(step) == S_TONE_SET && !silence_path) begin
            divider_top  <= top_clamped;
            remaining_ms <= op_dur;
            sounding     <= 1'b1;
          end else begin
            sounding        <= 1'b0;
            notes_in_melody <= '0;
          end
        end
        DP_EMIT: begin
          if (!out_full) begin
            out_valid      <= 1'b1;
            tone_active    <= sounding;
            compare_top    <= sounding ? divider_top : '0;
            melody_running <= (notes_in_melody != '0);
            current_note   <= (notes_in_melody != '0) ? NOTE_W'(note_position) : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      came_from_div <= 1'b0;
    end else begin
      came_from_div <= (step == S_DIV_WAIT);
    end
  end

  assign silence_path = !came_from_div;

  tms_div #(
    .DIVIDEND_W(DIVIDEND_W),
    .DIVISOR_W (FREQ_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(cpu_clock_hz[CLK_W-1:PRESCALE_SHIFT]),
    .divisor (op_freq),
    .busy    (div_busy),
    .quotient(div_quotient)
  );

  tms_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_NOTES)
  ) u_note_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(IDX_W'(item_slot)),
    .wdata({item_dur, item_freq}),
    .raddr(note_position),
    .rdata(store_rdata)
  );

endmodule

[tb/sv/tone_melody_checker.sv]
// Checker for the tone melody sequencer: predicts every result and compares it on arrival.
module tone_melody_checker #(
  parameter int NOTE_SLOTS = tms_pkg::MAX_NOTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tms_pkg::CLK_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tms_pkg::KIND_W-1:0]  kind,
  input  logic [tms_pkg::FREQ_W-1:0]  frequency_hz,
  input  logic [tms_pkg::DUR_W-1:0]   length_ms,
  input  logic [tms_pkg::LEN_W-1:0]   melody_length,
  input  logic [tms_pkg::SLOT_W-1:0]  note_slot,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        tone_active,
  input  logic [tms_pkg::TOP_W-1:0]   compare_top,
  input  logic                        melody_running,
  input  logic [tms_pkg::NOTE_W-1:0]  current_note,
  output int                          outstanding,
  output int                          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tms_pkg::*;

  typedef struct packed {
    logic              active;
    logic [TOP_W-1:0]  top;
    logic              running;
    logic [NOTE_W-1:0] note;
  } tone_status_t;

  logic [CLK_W-1:0]  clock_hz;
  logic              sounding;
  logic [DUR_W-1:0]  ms_left;
  logic [LEN_W-1:0]  melody_len;
  logic [NOTE_W-1:0] position;
  logic [TOP_W-1:0]  divider;
  logic [FREQ_W-1:0] note_freq [NOTE_SLOTS];
  logic [DUR_W-1:0]  note_dur  [NOTE_SLOTS];
  tone_status_t      status_queue [$];
  int                failures = 0;

  function automatic void fall_silent();
    sounding   = 1'b0;
    melody_len = '0;
  endfunction

  // The compare top is the clock over sixteen times the frequency less one, clamped; a zero quotient stays zero.
  function automatic void sound_tone(input logic [FREQ_W-1:0] freq,
                                     input logic [DUR_W-1:0] dur);
    logic [31:0] quotient;
    if (freq == '0) begin
      fall_silent();
    end else begin
      quotient = 32'(clock_hz) / (32'd16 * 32'(freq));
      if (quotient != 0)
        quotient = quotient - 32'd1;
      if (quotient > 32'(TOP_MAX))
        quotient = 32'(TOP_MAX);
      divider  = quotient[TOP_W-1:0];
      ms_left  = dur;
      sounding = 1'b1;
    end
  endfunction

  function automatic tone_status_t predict_status(input logic [KIND_W-1:0] k,
                                                  input logic [FREQ_W-1:0] freq,
                                                  input logic [DUR_W-1:0]  dur,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [SLOT_W-1:0] slot);
    tone_status_t s;
    case (k)
      KIND_TICK: begin
        if (sounding) begin
          if (ms_left != '0)
            ms_left = ms_left - 1'b1;
          if (ms_left == '0) begin
            if (melody_len != '0 && ({1'b0, position} + 5'd1) < melody_len) begin
              position = position + 1'b1;
              sound_tone(note_freq[position], note_dur[position]);
            end else begin
              fall_silent();
            end
          end
        end
      end
      KIND_TONE: begin
        melody_len = '0;
        sound_tone(freq, dur);
      end
      KIND_MELODY: begin
        if (len == '0) begin
          fall_silent();
        end else begin
          melody_len = (len > LEN_W'(NOTE_SLOTS)) ? LEN_W'(NOTE_SLOTS) : len;
          position   = '0;
          sound_tone(note_freq[0], note_dur[0]);
        end
      end
      KIND_LOAD: begin
        if (int'(slot) < NOTE_SLOTS) begin
          note_freq[slot] = freq;
          note_dur[slot]  = dur;
        end
      end
      KIND_STOP: fall_silent();
      default: ;
    endcase
    s.active  = sounding;
    s.top     = sounding ? divider : '0;
    s.running = (melody_len != '0);
    s.note    = (melody_len != '0) ? position : '0;
    return s;
  endfunction

  function automatic void report_failure(input string what);
    failures++;
    if (failures <= 10)
      $display("%0t: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    tone_status_t seen;
    tone_status_t want;
    if (rst) begin
      status_queue.delete();
      clock_hz   = CPU_CLOCK_RESET;
      sounding   = 1'b0;
      ms_left    = '0;
      melody_len = '0;
      position   = '0;
      divider    = '0;
    end else begin
      if (cfg_valid && cfg_ready)
        clock_hz = cfg_data;
      // A result is checked before the item taken at the same edge is predicted.
      if (out_valid && out_ready) begin
        seen = '{tone_active, compare_top, melody_running, current_note};
        if (status_queue.size() == 0) begin
          report_failure($sformatf("result with none expected: active=%0b top=%0h running=%0b note=%0d",
                                   seen.active, seen.top, seen.running, seen.note));
        end else begin
          want = status_queue.pop_front();
          if (seen.active !== want.active || seen.top !== want.top ||
              seen.running !== want.running || seen.note !== want.note)
            report_failure($sformatf({"mismatch: expected active=%0b top=%0h running=%0b note=%0d,",
                                      " got active=%0b top=%0h running=%0b note=%0d"},
                                     want.active, want.top, want.running, want.note,
                                     seen.active, seen.top, seen.running, seen.note));
        end
      end
      if (in_valid && in_ready)
        status_queue.push_back(predict_status(kind, frequency_hz, length_ms,
                                              melody_length, note_slot));
    end
    outstanding <= status_queue.size();
    fail_count  <= failures;
  end

endmodule

[tb/sv/tb_tone_melody_sequencer.sv]
// Testbench top for the tone melody sequencer: stimulus, flow control and the verdict.
module tb_tone_melody_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import tms_pkg::*;

  // Clock settings within the range a real system would use.
  localparam int CLOCK_HZ_LOW  = 1000000;
  localparam int CLOCK_HZ_HIGH = 32000000;
  // Items counted per random phase; kinds the block ignores are not counted.
  localparam int PHASE_ITEMS   = 130;
  localparam int PHASE_COUNT   = 5;
  // The longest quiet stretch of a correct run is a sender gap, a tick that starts the next
  // note and a receiver stall in a row; the limit allows many times that.
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CLK_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  kind;
  logic [FREQ_W-1:0]  frequency_hz;
  logic [DUR_W-1:0]   length_ms;
  logic [LEN_W-1:0]   melody_length;
  logic [SLOT_W-1:0]  note_slot;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               tone_active;
  logic [TOP_W-1:0]   compare_top;
  logic               melody_running;
  logic [NOTE_W-1:0]  current_note;

  int                 outstanding;
  int                 fail_count;

  // Percentage that sets how often either side idles; zero means a steady stream.
  int                 idle_pct = 0;
  int                 stall_left = 0;
  int                 quiet_cycles = 0;
  int                 real_items = 0;
  int                 clock_settings = 0;
  int                 kind_seen [8];
  // Which note store entries hold a loaded note. A melody never reaches an unloaded one.
  logic [MAX_NOTES_DEF-1:0] slot_loaded = '0;

  always #1 clk = ~clk;

  tone_melody_sequencer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .frequency_hz   (frequency_hz),
    .length_ms      (length_ms),
    .melody_length  (melody_length),
    .note_slot      (note_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tone_active    (tone_active),
    .compare_top    (compare_top),
    .melody_running (melody_running),
    .current_note   (current_note)
  );

  tone_melody_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .frequency_hz   (frequency_hz),
    .length_ms      (length_ms),
    .melody_length  (melody_length),
    .note_slot      (note_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tone_active    (tone_active),
    .compare_top    (compare_top),
    .melody_running (melody_running),
    .current_note   (current_note),
    .outstanding    (outstanding),
    .fail_count     (fail_count)
  );

  // The receiver stalls in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 8) begin
      stall_left <= $urandom_range(1, 16);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // The watchdog counts cycles in which no channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_tone_melody_sequencer: errors");
      $finish;
    end
  end

  // Offers one item and returns at the edge of its transfer, with valid still raised so that
  // a following item can be offered in the same step without a drop in between.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [FREQ_W-1:0] f,
                           input logic [DUR_W-1:0] d, input logic [LEN_W-1:0] n,
                           input logic [SLOT_W-1:0] s);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    frequency_hz  <= f;
    length_ms     <= d;
    melody_length <= n;
    note_slot     <= s;
    do @(posedge clk); while (!in_ready);
    kind_seen[k]++;
    if (k <= KIND_STOP)
      real_items++;
    if (k == KIND_LOAD)
      slot_loaded[s] = 1'b1;
  endtask

  // Holds the sender back until every expected result has been seen by the checker.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes the clock frequency register; only ever called while the block is idle.
  task automatic write_clock_hz(input logic [CLK_W-1:0] hz);
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_settings++;
  endtask

  // Random items are mostly ticks, loads and melodies so that melodies really advance
  // through the note store; the rest are single tones, stops and the unused kinds.
  task automatic send_random_item();
    int               pick;
    int               prefix;
    logic [KIND_W-1:0] k;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    logic [LEN_W-1:0]  n;
    logic [SLOT_W-1:0] s;
    prefix = 0;
    while (prefix < MAX_NOTES_DEF && slot_loaded[prefix])
      prefix++;
    case ($urandom_range(0, 9))
      0:       f = '0;
      1:       f = TOP_MAX;
      2, 3:    f = FREQ_W'($urandom_range(1, 40));
      4, 5, 6: f = FREQ_W'($urandom_range(100, 5000));
      default: f = FREQ_W'($urandom_range(1, 65535));
    endcase
    d = ($urandom_range(0, 9) < 8) ? DUR_W'($urandom_range(0, 4)) : DUR_W'($urandom);
    n = LEN_W'($urandom_range(0, 31));
    s = SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45)
      k = KIND_TICK;
    else if (pick < 55)
      k = KIND_TONE;
    else if (pick < 67)
      k = KIND_MELODY;
    else if (pick < 88)
      k = KIND_LOAD;
    else if (pick < 95)
      k = KIND_STOP;
    else
      k = KIND_STOP + KIND_W'($urandom_range(1, 3));
    // Fill the store from the bottom up more quickly than chance alone would.
    if (k == KIND_LOAD && prefix < MAX_NOTES_DEF && $urandom_range(0, 1) == 1)
      s = SLOT_W'(prefix);
    // A melody may only span entries that have been loaded.
    if (k == KIND_MELODY && ((n > LEN_W'(MAX_NOTES_DEF)) ? MAX_NOTES_DEF : int'(n)) > prefix)
      n = LEN_W'(prefix);
    send_item(k, f, d, n, s);
  endtask

  initial begin
    int target;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    kind          <= KIND_TICK;
    frequency_hz  <= '0;
    length_ms     <= '0;
    melody_length <= '0;
    note_slot     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 30;
    write_clock_hz(CPU_CLOCK_RESET);

    // Directed part. A tick and a stop while silent change nothing.
    send_item(KIND_TICK,   TOP_MAX, 16'hFFFF, 5'd31, 4'hF);
    send_item(KIND_STOP,   TOP_MAX, 16'hFFFF, 5'd31, 4'hF);
    // The lowest frequency overflows sixteen bits and is clamped; a zero duration ends
    // on the first tick.
    send_item(KIND_TONE,   16'd1,     16'd0,    5'd0, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    // The highest frequency gives the smallest compare top; it ends on the second tick.
    send_item(KIND_TONE,   TOP_MAX,   16'd2,    5'd0, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    send_item(KIND_TONE,   16'd1000,  16'hFFFF, 5'd0, 4'h0);
    // A zero frequency silences a sounding tone.
    send_item(KIND_TONE,   16'd0,     16'hFFFF, 5'd0, 4'h0);
    // The unused kinds only report the status.
    send_item(KIND_STOP + KIND_W'(1), 16'd500, 16'd9, 5'd3, 4'h3);
    send_item(KIND_STOP + KIND_W'(3), 16'd500, 16'd9, 5'd3, 4'h3);
    // An empty melody, then a short melody whose last note has a zero frequency.
    send_item(KIND_LOAD,   16'd440,   16'd1,    5'd0, 4'h0);
    send_item(KIND_LOAD,   TOP_MAX,   16'd0,    5'd0, 4'h1);
    send_item(KIND_LOAD,   16'd0,     16'd3,    5'd0, 4'h2);
    send_item(KIND_MELODY, 16'd0,     16'd0,    5'd0, 4'h0);
    send_item(KIND_MELODY, 16'd0,     16'd0,    5'd3, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    // A single tone cancels a running melody.
    send_item(KIND_MELODY, 16'd0,     16'd0,    5'd2, 4'h0);
    send_item(KIND_TONE,   16'd2000,  16'd5,    5'd0, 4'h0);
    // A one-note melody has no next note and ends with its tone.
    send_item(KIND_MELODY, 16'd0,     16'd0,    5'd1, 4'h0);
    send_item(KIND_TICK,   16'd0,     16'd0,    5'd0, 4'h0);
    // A stop ends a melody part-way through.
    send_item(KIND_MELODY, 16'd0,     16'd0,    5'd3, 4'h0);
    send_item(KIND_STOP,   16'd0,     16'd0,    5'd0, 4'h0);

    // Random phases, each at its own clock setting and idling rate; the last runs steady.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      case (p)
        0: begin
          write_clock_hz(CLK_W'(CLOCK_HZ_HIGH));
          idle_pct = 25;
        end
        1: begin
          write_clock_hz(CLK_W'(CLOCK_HZ_LOW));
          idle_pct = 0;
        end
        2: begin
          write_clock_hz(CLK_W'($urandom_range(CLOCK_HZ_LOW, CLOCK_HZ_HIGH)));
          idle_pct = 40;
        end
        3: begin
          write_clock_hz(CLK_W'($urandom_range(CLOCK_HZ_LOW, CLOCK_HZ_HIGH)));
          idle_pct = 20;
        end
        default: begin
          write_clock_hz(CPU_CLOCK_RESET);
          idle_pct = 0;
        end
      endcase
      target = real_items + PHASE_ITEMS;
      while (real_items < target) begin
        // Halfway through one phase the sender waits for every result to come back.
        if (p == 2 && real_items == target - PHASE_ITEMS / 2)
          drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (64) @(posedge clk);

    $display("summary: %0d items (%0d ticks, %0d tones, %0d melodies, %0d loads, %0d stops)",
             real_items, kind_seen[KIND_TICK], kind_seen[KIND_TONE], kind_seen[KIND_MELODY],
             kind_seen[KIND_LOAD], kind_seen[KIND_STOP]);
    $display("summary: %0d items of unused kinds, %0d clock settings, %0d failures",
             kind_seen[5] + kind_seen[6] + kind_seen[7], clock_settings, fail_count);
    if (fail_count == 0)
      $display("tb_tone_melody_sequencer: clean");
    else
      $display("tb_tone_melody_sequencer: errors");
    $finish;
  end

endmodule

[files.f]
hdl/tms_pkg.sv
hdl/tms_ram.sv
hdl/tms_div.sv
hdl/tone_melody_sequencer.sv
tb/sv/tone_melody_checker.sv
tb/sv/tb_tone_melody_sequencer.sv
